[sv/sha1md_pkg.sv]
// package: types, constants and round helpers for the sha-1 digest block
`timescale 1ns / 1ps
`default_nettype none
package sha1md_pkg;
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int ROUNDS = 80;

  typedef enum logic [3:0] {
    ST_IDLE,    // take a byte
    ST_PAD,     // write pad byte
    ST_ZERO,    // zero remaining words
    ST_LEN_HI,  // write length high word
    ST_LEN_LO,  // write length low word
    ST_INIT,    // load working variables from the chain
    ST_RD,      // first schedule read
    ST_RD2,     // second read
    ST_RD3,     // third read
    ST_RD4,     // fourth read
    ST_RND,     // one round
    ST_ADD,     // add into chain
    ST_OUT      // digest waiting
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (r < 7'd20) round_f = (b & c) | (~b & d);
    else if (r < 7'd40) round_f = b ^ c ^ d;
    else if (r < 7'd60) round_f = (b & c) | (b & d) | (c & d);
    else round_f = b ^ c ^ d;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20) round_k = K0;
    else if (r < 7'd40) round_k = K1;
    else if (r < 7'd60) round_k = K2;
    else round_k = K3;
  endfunction
endpackage
`default_nettype wire

[sv/sha1md_if.sv]
// interfaces: byte request channel and digest channel
`timescale 1ns / 1ps
`default_nettype none
interface sha1md_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_item;
  modport source (output valid, data_byte, byte_present, last_item, input ready);
  modport sink (input valid, data_byte, byte_present, last_item, output ready);
endinterface

interface sha1md_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;
  modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
                  digest_word4, input ready);
  modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
                digest_word4, output ready);
endinterface
`default_nettype wire

[sv/sha1_message_digest.sv]
// top level: byte-serial sha-1 engine around a 16-word block memory
// Bytes are packed big-endian into a 16x32 block memory (one write port,
// registered read) and each full block is compressed in 80 rounds. A byte that
// does not complete a block is written into the memory and the block stays
// ready. A byte that completes a block starts a compression: the working
// variables are loaded, each of 16 early rounds issues a read and then runs
// the round, each of 64 later rounds first issues four reads (w[t-3], w[t-8],
// w[t-14], w[t]) through the single read port for the schedule word, and the
// chain is updated. A last request then writes the pad byte, clears the
// remaining words (up to 13), writes the two length words and compresses the
// block; when the length no longer fits, a second compression and the clearing
// of 14 words come on top. The digest is then held until taken. No new request
// is accepted while a block compresses or a digest waits.
`timescale 1ns / 1ps
`default_nettype none
module sha1_message_digest
  import sha1md_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  sha1md_in_if.sink    in_ch,
  sha1md_out_if.source out_ch
);
  state_t state, state_next;

  logic [31:0] mem [16];
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata;

  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] wacc, cur_word;
  logic [63:0] bit_count;
  logic [5:0]  byte_position;
  logic [6:0]  round_counter;
  logic        last_pend;  // padding still due after this compression
  logic        second;     // this compression is the first of two final blocks
  logic        final_blk;  // this compression is the final block
  logic [3:0]  zidx;
  logic [3:0]  zend;

  logic        in_fire;
  logic        out_fire;
  logic [3:0]  r4;
  logic        early;
  logic [5:0]  pad_next;
  logic [4:0]  zstart;
  logic        two_blk;
  logic [7:0]  put_v;
  logic [31:0] merged;
  logic [31:0] w_round;
  logic [31:0] a_next;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign r4       = round_counter[3:0];
  assign early    = (round_counter < 7'd16);

  // padding geometry: slot after the pad byte and first whole word to clear
  assign pad_next = byte_position + 6'd1;
  assign zstart   = {1'b0, pad_next[5:2]} + {4'd0, (pad_next[1:0] != 2'd0)};
  assign two_blk  = (pad_next == 6'd0) || (pad_next > 6'd56);

  // schedule word and round sum
  assign w_round = early ? rdata : rotl(wacc ^ rdata, 5'd1);
  assign a_next  = rotl(a, 5'd5) + round_f(round_counter, b, c, d) + e
                   + round_k(round_counter) + w_round;

  // block memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // byte merge into the current word
  always_comb begin
    put_v = (state == ST_PAD) ? PAD_BYTE : in_ch.data_byte;
    case (byte_position[1:0])
      2'd0: merged = {put_v, 24'd0};
      2'd1: merged = {cur_word[31:24], put_v, 16'd0};
      2'd2: merged = {cur_word[31:16], put_v, 8'd0};
      default: merged = {cur_word[31:8], put_v};
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = byte_position[5:2];
    wdata = merged;
    raddr = r4;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.byte_present) begin
            we = 1'b1;
            if (byte_position == 6'd63) state_next = ST_INIT;
            else if (in_ch.last_item) state_next = ST_PAD;
          end else if (in_ch.last_item) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        we = 1'b1;
        if (two_blk) state_next = (zstart[4] || pad_next == 6'd0) ? ST_INIT : ST_ZERO;
        else state_next = (zstart > 5'd13) ? ST_LEN_HI : ST_ZERO;
      end
      ST_ZERO: begin
        we = 1'b1;
        waddr = zidx;
        wdata = '0;
        if (zidx == zend) state_next = (zend == 4'd15) ? ST_INIT : ST_LEN_HI;
      end
      ST_LEN_HI: begin
        we = 1'b1; waddr = 4'd14; wdata = bit_count[63:32];
        state_next = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        we = 1'b1; waddr = 4'd15; wdata = bit_count[31:0];
        state_next = ST_INIT;
      end
      ST_INIT: state_next = ST_RD;
      ST_RD: begin
        raddr = early ? r4 : r4 - 4'd3;
        state_next = early ? ST_RND : ST_RD2;
      end
      ST_RD2: begin raddr = r4 - 4'd8; state_next = ST_RD3; end
      ST_RD3: begin raddr = r4 - 4'd14; state_next = ST_RD4; end
      ST_RD4: begin raddr = r4; state_next = ST_RND; end
      ST_RND: begin
        // later rounds write the schedule word back in place
        we = !early;
        waddr = r4;
        wdata = w_round;
        state_next = (round_counter == 7'(ROUNDS - 1)) ? ST_ADD : ST_RD;
      end
      ST_ADD: begin
        if (final_blk) state_next = ST_OUT;
        else if (second) state_next = ST_ZERO;
        else if (last_pend) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_OUT: if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
      a <= '0; b <= '0; c <= '0; d <= '0; e <= '0;
      wacc <= '0; cur_word <= '0;
      bit_count <= '0; byte_position <= '0; round_counter <= '0;
      last_pend <= 1'b0; second <= 1'b0; final_blk <= 1'b0;
      zidx <= '0; zend <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (in_fire && in_ch.byte_present) begin
          cur_word <= merged;
          byte_position <= byte_position + 6'd1;
          bit_count <= bit_count + 64'd8;
          last_pend <= in_ch.last_item;
        end
        ST_PAD: begin
          byte_position <= pad_next;
          last_pend <= 1'b0;
          second <= two_blk;
          zidx <= zstart[3:0];
          zend <= two_blk ? 4'd15 : 4'd13;
        end
        ST_ZERO: if (zidx != zend) zidx <= zidx + 4'd1;
        ST_LEN_HI: ;
        ST_LEN_LO: final_blk <= 1'b1;
        ST_INIT: begin
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          round_counter <= '0;
        end
        ST_RD: ;
        ST_RD2: wacc <= rdata;
        ST_RD3: wacc <= wacc ^ rdata;
        ST_RD4: wacc <= wacc ^ rdata;
        ST_RND: begin
          a <= a_next;
          b <= a; c <= rotl(b, 5'd30); d <= c; e <= d;
          if (round_counter == 7'(ROUNDS - 1)) round_counter <= '0;
          else round_counter <= round_counter + 7'd1;
        end
        ST_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          // second final block: clear everything below the length
          if (!final_blk && second) begin
            second <= 1'b0; zidx <= '0; zend <= 4'd13;
          end
        end
        ST_OUT: if (out_fire) begin
          h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
          bit_count <= '0; byte_position <= '0; final_blk <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.digest_word0 = h[0];
  assign out_ch.digest_word1 = h[1];
  assign out_ch.digest_word2 = h[2];
  assign out_ch.digest_word3 = h[3];
  assign out_ch.digest_word4 = h[4];

  // no request taken while a digest waits
  a_no_in_when_out: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("request taken with digest pending");
  // round counter stays in range
  a_round_range: assert property (@(posedge clk) disable iff (rst)
    round_counter < 7'(ROUNDS)) else $error("round counter out of range");
  // digest holds until taken
  a_digest_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid &&
      $stable({out_ch.digest_word0, out_ch.digest_word1, out_ch.digest_word2,
               out_ch.digest_word3, out_ch.digest_word4}))
    else $error("digest changed while waiting");
  // clearing pointer never passes its end
  a_zero_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ZERO |-> zidx <= zend) else $error("clear pointer past end");
endmodule
`default_nettype wire

[dv/tb_sha1_message_digest.sv]
// testbench: byte-serial sha-1 digest block checked against a built-in digest predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_sha1_message_digest
  import sha1md_pkg::*;
();

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_item;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    logic [31:0] w4;
  } digest_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN = 2000;

  logic clk;
  logic rst;

  sha1md_in_if  in_ch ();
  sha1md_out_if out_ch ();

  sha1_message_digest DUT (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // predictor state
  logic [31:0] hash_state [5];
  logic [31:0] msg_block [16];
  logic [63:0] msg_bits;
  int          fill_pos;

  byte_req_t   pending_reqs [$];
  digest_t     expected_digests [$];
  int          error_count = 0;
  bit          calm_phase;
  bit          hold_sink;
  bit          src_pause;
  int          idle_cycles;
  bit          in_fire;
  byte_req_t   drv_req;
  byte_req_t   mon_req;
  digest_t     mon_dg;

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
    d = hash_state[3]; e = hash_state[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16)
        w[r % 16] = rol32(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16], 1);
      if (r < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol32(a, 5) + f + e + k + w[r % 16];
      e = d; d = c; c = rol32(b, 30); b = a; a = t;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
    hash_state[3] += d; hash_state[4] += e;
  endtask

  task automatic append_byte(logic [7:0] v);
    msg_block[fill_pos / 4][8 * (3 - fill_pos % 4) +: 8] = v;
    fill_pos = (fill_pos + 1) % 64;
  endtask

  task automatic restart_digest();
    hash_state[0] = IV0; hash_state[1] = IV1; hash_state[2] = IV2;
    hash_state[3] = IV3; hash_state[4] = IV4;
    msg_bits = 64'd0;
    fill_pos = 0;
    for (int i = 0; i < 16; i++) msg_block[i] = 32'd0;
  endtask

  // digest prediction for one accepted request
  task automatic predict_digest(byte_req_t req);
    digest_t dg;
    if (req.byte_present) begin
      append_byte(req.data_byte);
      msg_bits += 64'd8;
      if (fill_pos == 0) compress_block();
    end
    if (!req.last_item) return;
    append_byte(PAD_BYTE);
    // two final blocks when the length no longer fits behind the pad byte
    if (fill_pos == 0 || fill_pos > 56) begin
      while (fill_pos != 0) append_byte(8'h00);
      compress_block();
      for (int i = 0; i < 14; i++) msg_block[i] = 32'd0;
    end else begin
      while (fill_pos < 56) append_byte(8'h00);
    end
    msg_block[14] = msg_bits[63:32];
    msg_block[15] = msg_bits[31:0];
    compress_block();
    dg = '{hash_state[0], hash_state[1], hash_state[2], hash_state[3], hash_state[4]};
    expected_digests.push_back(dg);
    restart_digest();
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch: %s at %0t", msg, $time);
    error_count++;
  endtask

  // monitor: accepts sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
      idle_cycles <= 0;
      restart_digest();
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        mon_req = '{in_ch.data_byte, in_ch.byte_present, in_ch.last_item};
        predict_digest(mon_req);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_digests.size() == 0) begin
          report_mismatch("unexpected digest");
        end else begin
          mon_dg = expected_digests.pop_front();
          if (out_ch.digest_word0 !== mon_dg.w0)
            report_mismatch($sformatf("word0 got %08h expected %08h",
                                      out_ch.digest_word0, mon_dg.w0));
          if (out_ch.digest_word1 !== mon_dg.w1)
            report_mismatch($sformatf("word1 got %08h expected %08h",
                                      out_ch.digest_word1, mon_dg.w1));
          if (out_ch.digest_word2 !== mon_dg.w2)
            report_mismatch($sformatf("word2 got %08h expected %08h",
                                      out_ch.digest_word2, mon_dg.w2));
          if (out_ch.digest_word3 !== mon_dg.w3)
            report_mismatch($sformatf("word3 got %08h expected %08h",
                                      out_ch.digest_word3, mon_dg.w3));
          if (out_ch.digest_word4 !== mon_dg.w4)
            report_mismatch($sformatf("word4 got %08h expected %08h",
                                      out_ch.digest_word4, mon_dg.w4));
        end
      end
      if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // request driver: head of queue presented, random bursts of gaps
  int src_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid        <= 1'b0;
      in_ch.data_byte    <= 8'd0;
      in_ch.byte_present <= 1'b0;
      in_ch.last_item    <= 1'b0;
      src_gap = 0;
    end else if (in_ch.valid && !in_fire) begin
      // a held request stays until the edge that takes it
    end else if (src_pause || pending_reqs.size() == 0) begin
      in_ch.valid <= 1'b0;
    end else if (src_gap > 0) begin
      src_gap--;
      in_ch.valid <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
      src_gap = $urandom_range(0, 17);
      in_ch.valid <= 1'b0;
    end else begin
      drv_req = pending_reqs.pop_front();
      in_ch.valid        <= 1'b1;
      in_ch.data_byte    <= drv_req.data_byte;
      in_ch.byte_present <= drv_req.byte_present;
      in_ch.last_item    <= drv_req.last_item;
    end
  end

  // digest receiver: random stall bursts plus one long hold-off
  int sink_gap;
  int hold_cycles;
  bit hold_used;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
      hold_cycles = 0;
      hold_used = 1'b0;
    end else if (hold_sink && !hold_used) begin
      hold_used = 1'b1;
      hold_cycles = HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ch.ready <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic add_message(int len, bit empty_last);
    byte_req_t r;
    for (int i = 0; i < len; i++) begin
      r.data_byte    = 8'($urandom_range(0, 255));
      r.byte_present = 1'b1;
      r.last_item    = (i == len - 1) && !empty_last;
      pending_reqs.push_back(r);
      if ($urandom_range(0, 19) == 0) begin
        r.byte_present = 1'b0;
        r.last_item    = 1'b0;
        r.data_byte    = 8'($urandom_range(0, 255));
        pending_reqs.push_back(r);
      end
    end
    if (empty_last || len == 0) begin
      r.data_byte    = 8'($urandom_range(0, 255));
      r.byte_present = 1'b0;
      r.last_item    = 1'b1;
      pending_reqs.push_back(r);
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_digests.size() != 0)
      @(posedge clk);
  endtask

  // watchdog
  always @(posedge clk) begin
    if (!rst && idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  int sent;
  initial begin
    byte_req_t r;
    calm_phase = 0;
    hold_sink = 0;
    src_pause = 0;
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty message, one byte, extremes
    add_message(0, 1'b1);
    r = '{8'hFF, 1'b1, 1'b1}; pending_reqs.push_back(r);
    r = '{8'h00, 1'b1, 1'b1}; pending_reqs.push_back(r);
    r = '{8'hA5, 1'b0, 1'b0}; pending_reqs.push_back(r);
    r = '{8'h5A, 1'b1, 1'b0}; pending_reqs.push_back(r);
    add_message(2, 1'b1);
    add_message(5, 1'b0);
    wait_drained();

    // long receiver hold-off while requests keep coming
    hold_sink = 1;
    add_message(3, 1'b0);
    add_message(1, 1'b0);
    add_message(2, 1'b1);
    while (!hold_used || hold_cycles > 0) @(posedge clk);
    wait_drained();

    // boundary lengths: 55, 56, 63, 64 bytes
    add_message(55, 1'b0);
    add_message(56, 1'b0);
    add_message(63, 1'b1);
    add_message(64, 1'b0);
    wait_drained();

    // random messages, mostly short
    sent = 0;
    while (sent < 240) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 12);
      add_message(len, $urandom_range(0, 3) == 0);
      sent += len + 1;
      if ($urandom_range(0, 5) == 0) begin
        // sender stops until every digest owed so far is out
        src_pause = 1;
        while (in_ch.valid || expected_digests.size() != 0) @(posedge clk);
        src_pause = 0;
      end else begin
        while (pending_reqs.size() > 40) @(posedge clk);
      end
    end
    wait_drained();

    // last part with no idling
    calm_phase = 1;
    for (int i = 0; i < 10; i++)
      add_message($urandom_range(0, 20), $urandom_range(0, 1) == 1);
    wait_drained();

    // room for any stray digest to show up
    repeat (1000) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
sv/sha1md_pkg.sv
sv/sha1md_if.sv
sv/sha1_message_digest.sv
dv/tb_sha1_message_digest.sv
